FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL files; wrr_datapath includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define WRR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property failed");

`define WRR_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define WRR_ASSERT(label, clk, rst_n, prop)

`define WRR_NEVER(label, clk, rst_n, expr)

`endif

`endif

FILE: rtl/wrr_pkg.sv
package wrr_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_PICK   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_NOTHING   = 2'd3;

    localparam logic [7:0] LONGEST_SLICE_RESET = 8'd8;

    typedef struct packed {
        logic       cap;
        logic       add;
        logic       scan_init;
        logic       scan_rd;
        logic       scan_adv;
        logic       shift_rd;
        logic       shift_wr;
        logic       remove_done;
        logic       pick_rd;
        logic       pick_wr;
        logic       pick_empty;
        logic       res_set;
        logic [1:0] res_code;
        logic       load_out;
    } wrr_ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       empty;
        logic       scan_end;
        logic       match;
        logic       shift_end;
        logic       out_busy;
    } wrr_stat_t;

endpackage

FILE: rtl/wrr_ctrl.sv
module wrr_ctrl
    import wrr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  wrr_stat_t st,
    output wrr_ctrl_t c
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CMP = 3'd3;
    localparam logic [2:0] S_SHIFT_RD = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;
    localparam logic [2:0] S_PICK_WR  = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        c          = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    c.cap      = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.cmd)
                    CMD_ADD:
                    begin
                        if (st.full)
                        begin
                            c.res_set  = 1'b1;
                            c.res_code = ST_FULL;
                        end
                        else
                        begin
                            c.add = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    CMD_REMOVE:
                    begin
                        c.scan_init = 1'b1;
                        state_next  = S_SCAN_RD;
                    end
                    CMD_PICK:
                    begin
                        if (st.empty)
                        begin
                            c.pick_empty = 1'b1;
                            c.res_set    = 1'b1;
                            c.res_code   = ST_NOTHING;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            c.pick_rd  = 1'b1;
                            state_next = S_PICK_WR;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                if (st.scan_end)
                begin
                    c.res_set  = 1'b1;
                    c.res_code = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    c.scan_rd  = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (st.match)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    c.scan_adv = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (st.shift_end)
                begin
                    c.remove_done = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    c.shift_rd = 1'b1;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                c.shift_wr = 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_PICK_WR:
            begin
                c.pick_wr  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!st.out_busy)
                begin
                    c.load_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/wrr_datapath.sv
`include "assert_macros.svh"

module wrr_datapath
    import wrr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  wrr_ctrl_t  c,
    output wrr_stat_t  st,
    input  logic [1:0] command,
    input  logic [7:0] entity_id,
    input  logic [1:0] priority_class,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       out_ready,
    output logic       out_valid,
    output logic [1:0] status,
    output logic [7:0] picked_id,
    output logic [1:0] serving_class
);

    localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = $clog2(2 * QUEUE_DEPTH);
    localparam int ADDR_W    = SLOT_W + 2;
    localparam int MEM_DEPTH = 4 << SLOT_W;

    logic [ID_WIDTH-1:0] mem_reg [MEM_DEPTH];
    logic [ID_WIDTH-1:0] rd_data_reg;

    logic [SLOT_W-1:0] head_reg  [4];
    logic [CNT_W-1:0]  count_reg [4];

    logic [1:0]          cmd_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [1:0]          cls_reg;
    logic [SLOT_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [1:0]          res_reg;
    logic [7:0]          pick_reg;

    logic [1:0] serving_reg;
    logic [7:0] slice_len_reg;
    logic [7:0] slice_used_reg;
    logic [7:0] longest_reg;

    logic       out_valid_reg;
    logic [1:0] out_status_reg;
    logic [7:0] out_picked_reg;
    logic [1:0] out_class_reg;

    logic [1:0]          sel_cls;
    logic [SLOT_W-1:0]   head_sel;
    logic [CNT_W-1:0]    count_sel;
    logic [SLOT_W-1:0]   head_inc;
    logic [SLOT_W-1:0]   ptr_inc;
    logic [SUM_W-1:0]    tail_sum;
    logic [SUM_W-1:0]    tail_wrap;
    logic [SLOT_W-1:0]   tail;
    logic [CNT_W:0]      idx_plus;
    logic [15:0]         id_wide;
    logic [15:0]         rd_wide;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [ID_WIDTH-1:0] mem_wdata;
    logic                mem_re;
    logic [8:0]          used_inc;
    logic                slice_expire;
    logic                slice_step;

    // Picks work on the serving class, adds and removes on the item's class.
    assign sel_cls   = (cmd_reg == CMD_PICK) ? serving_reg : cls_reg;
    assign head_sel  = head_reg[sel_cls];
    assign count_sel = count_reg[sel_cls];

    assign head_inc = (head_sel == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_sel + SLOT_W'(1);
    assign ptr_inc  = (ptr_reg == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_reg + SLOT_W'(1);

    // The tail slot is head plus count, wrapped once at the queue depth.
    assign tail_sum  = SUM_W'(head_sel) + SUM_W'(count_sel);
    assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
                                                         : tail_sum;
    assign tail      = tail_wrap[SLOT_W-1:0];

    assign idx_plus = {1'b0, idx_reg} + (CNT_W + 1)'(1);
    assign id_wide  = 16'(entity_id);
    assign rd_wide  = 16'(rd_data_reg);

    assign mem_we    = c.add | c.shift_wr | c.pick_wr;
    assign mem_wdata = c.add ? id_reg : rd_data_reg;
    assign mem_waddr = {sel_cls, (c.shift_wr ? ptr_reg : tail)};
    assign mem_re    = c.scan_rd | c.shift_rd | c.pick_rd;
    assign mem_raddr = {sel_cls, (c.pick_rd ? head_sel : (c.shift_rd ? ptr_inc : ptr_reg))};

    assign used_inc     = {1'b0, slice_used_reg} + 9'd1;
    assign slice_expire = used_inc > {1'b0, slice_len_reg};
    assign slice_step   = c.pick_wr | c.pick_empty;

    assign st.cmd       = cmd_reg;
    assign st.full      = (count_sel == CNT_W'(QUEUE_DEPTH));
    assign st.empty     = (count_sel == '0);
    assign st.scan_end  = (idx_reg == count_sel);
    assign st.match     = (rd_data_reg == id_reg);
    assign st.shift_end = (idx_plus >= {1'b0, count_sel});
    assign st.out_busy  = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign picked_id     = out_picked_reg;
    assign serving_class = out_class_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_reg[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem_reg[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (c.cap)
        begin
            cmd_reg  <= command;
            id_reg   <= id_wide[ID_WIDTH-1:0];
            cls_reg  <= priority_class;
            res_reg  <= ST_OK;
            pick_reg <= '0;
        end
        else
        begin
            if (c.res_set)
            begin
                res_reg <= c.res_code;
            end
            if (c.pick_wr)
            begin
                pick_reg <= rd_wide[7:0];
            end
        end
        if (c.scan_init)
        begin
            ptr_reg <= head_sel;
            idx_reg <= '0;
        end
        else if (c.scan_adv || c.shift_wr)
        begin
            ptr_reg <= ptr_inc;
            idx_reg <= idx_plus[CNT_W-1:0];
        end
        if (c.load_out)
        begin
            out_status_reg <= res_reg;
            out_picked_reg <= pick_reg;
            out_class_reg  <= serving_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (c.add)
            begin
                count_reg[sel_cls] <= count_sel + CNT_W'(1);
            end
            else if (c.remove_done)
            begin
                count_reg[sel_cls] <= count_sel - CNT_W'(1);
            end
            if (c.pick_wr)
            begin
                head_reg[sel_cls] <= head_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serving_reg    <= '0;
            slice_len_reg  <= LONGEST_SLICE_RESET;
            slice_used_reg <= '0;
            longest_reg    <= LONGEST_SLICE_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                longest_reg <= cfg_wdata;
            end
            if (slice_step)
            begin
                if (slice_expire)
                begin
                    serving_reg    <= serving_reg + 2'd1;
                    slice_used_reg <= '0;
                    slice_len_reg  <= (slice_len_reg <= 8'd1) ? longest_reg
                                                              : slice_len_reg >> 1;
                end
                else
                begin
                    slice_used_reg <= used_inc[7:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (c.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    `WRR_ASSERT(a_add_has_room, clk, rst_n, c.add |-> !st.full)
    `WRR_ASSERT(a_shift_in_queue, clk, rst_n, c.shift_wr |-> !st.shift_end)
    `WRR_NEVER(a_slice_in_range, clk, rst_n, slice_used_reg > slice_len_reg)
    `WRR_ASSERT(a_load_when_free, clk, rst_n, c.load_out |-> (!out_valid_reg || out_ready))

endmodule

FILE: rtl/four_class_weighted_round_robin_core.sv
// Four-class weighted round-robin scheduler with one FIFO run queue per class.
// Input channel s_axis: tuser carries the command (add, remove, pick), tdata
// carries the entity id and the priority class. Each accepted item yields
// exactly one result item on m_axis: tuser carries the status, tdata the
// picked id and the class that is serving after the item.
// The register port cfg_we/cfg_wdata sets the longest slice; a new value is
// used at the next slice reload.
// One item is worked on at a time. An add, and a pick that finds the serving
// queue empty, go from dispatch straight to the done state; a pick that returns
// an entry first reads it, then writes it back at the tail. A remove walks the
// class queue through the entry memory, reading and comparing each entry scanned,
// then reading and writing each entry moved when the gap is closed. Scanned and
// moved entries together equal the queue count. The next item is accepted in
// the cycle after a result loads.
// The finished result sits in an output register; the next item is accepted
// while it waits. If the receiver stalls, the following result is held inside
// and no further item is accepted until the output register frees up.
// Reset clears the queue pointers and counts, the slice state and the output
// valid; queue entries need no clearing since only written entries are read.
module four_class_weighted_round_robin_core
    import wrr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] entity_id, [9:8] priority_class
    input  logic [1:0]  s_axis_tuser,  // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] picked_id, [9:8] serving_class
    output logic [1:0]  m_axis_tuser,  // [1:0] status
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    wrr_ctrl_t  ctrl;
    wrr_stat_t  stat;
    logic [7:0] picked_id;
    logic [1:0] serving_class;

    wrr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (stat),
        .c        (ctrl)
    );

    wrr_datapath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .c              (ctrl),
        .st             (stat),
        .command        (s_axis_tuser),
        .entity_id      (s_axis_tdata[7:0]),
        .priority_class (s_axis_tdata[9:8]),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .status         (m_axis_tuser),
        .picked_id      (picked_id),
        .serving_class  (serving_class)
    );

    assign m_axis_tdata = {6'b0, serving_class, picked_id};

endmodule
